@@ design/ubxfr_pkg.sv @@
// ubxfr_pkg: shared types and constants for the UBX frame receiver.
// Used by ubxfr_front, ubxfr_queue, ubxfr_back and ubx_frame_receiver_top.
`timescale 1ns / 1ps

package ubxfr_pkg;

  localparam int unsigned MaxPayload = 256;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK_A = 3'd4,
    PH_CHECK_B = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADSUM  = 2'd1,
    ST_TOOLONG = 2'd2
  } status_t;

  // What the back end has to do with a queued request.
  typedef enum logic [2:0] {
    KIND_START   = 3'd0,  // sync seen: clear checksum
    KIND_DATA    = 3'd1,  // header or payload byte: sum and forward
    KIND_TOOLONG = 3'd2,  // length high byte over the limit: close frame
    KIND_CHECK_A = 3'd3,  // first check byte: hold it
    KIND_CHECK_B = 3'd4   // second check byte: compare and close frame
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [8:0] pos;
  } req_t;

endpackage

@@ design/ubx_frame_receiver_top.sv @@
// ubx_frame_receiver_top: top level of the UBX frame receiver.
// Instantiates ubxfr_front, ubxfr_queue and ubxfr_back; depends on ubxfr_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: one received serial byte per request on rx_byte, qualified
//   by in_valid; the block holds off new bytes with in_stall.
//   Output channel: forwarded header/payload bytes and the closing check byte
//   on data_byte with byte_pos, frame_end and frame_status, qualified by
//   out_valid; the sink holds a result with out_stall.
//   Sync bytes, hunted bytes and the first check byte yield no result.
// Timing
//   Throughput: one byte per cycle sustained while out_stall stays low. The front
//   end updates phase and length for each byte, the checksum unit adds one byte
//   per cycle. An accepted byte passes a queue entry, then the output register,
//   before it shows up on the outputs.
// Reset
//   rst (synchronous) returns to sync hunting, clears the checksum and empties
//   the request queue and the output register.
// Backpressure
//   While out_stall holds a result, the back end stops; the front end keeps
//   taking bytes until the two-entry queue fills, then raises in_stall.
module ubx_frame_receiver_top #(
  parameter int unsigned MAX_PAYLOAD = ubxfr_pkg::MaxPayload
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic [8:0] byte_pos,
  output logic       frame_end,
  output logic [1:0] frame_status
);

  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  ubxfr_pkg::req_t push_req;
  ubxfr_pkg::req_t q_req;

  // phase tracking and byte classification
  ubxfr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  // decouples input acceptance from output backpressure
  ubxfr_queue #(
    .DEPTH(ubxfr_pkg::QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .pop      (pop)
  );

  // Fletcher sum, check compare, output register
  ubxfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_pos     (byte_pos),
    .frame_end    (frame_end),
    .frame_status (frame_status)
  );

endmodule

@@ design/ubxfr_front.sv @@
// ubxfr_front: input side; tracks frame phase and classifies each received byte.
// Depends on ubxfr_pkg.
`timescale 1ns / 1ps

module ubxfr_front #(
  parameter int unsigned MAX_PAYLOAD = ubxfr_pkg::MaxPayload
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              push,
  output ubxfr_pkg::req_t   push_req
);

  ubxfr_pkg::phase_t phase, phase_next;
  logic [15:0] count, count_next;
  logic [15:0] len, len_next;
  logic        accept;
  logic [15:0] count_inc;
  logic [16:0] full_len;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign count_inc = count + 16'd1;
  assign full_len  = {1'b0, rx_byte, len[7:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ubxfr_pkg::PH_HUNT;
      count <= 16'd0;
      len   <= 16'd0;
    end else begin
      phase <= phase_next;
      count <= count_next;
      len   <= len_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    count_next    = count;
    len_next      = len;
    push          = 1'b0;
    push_req.kind = ubxfr_pkg::KIND_DATA;
    push_req.data = rx_byte;
    push_req.pos  = 9'd0;
    if (accept) begin
      case (phase)
        ubxfr_pkg::PH_SYNC2: begin
          if (rx_byte == ubxfr_pkg::SyncSecond) begin
            phase_next    = ubxfr_pkg::PH_HEADER;
            count_next    = 16'd0;
            len_next      = 16'd0;
            push          = 1'b1;
            push_req.kind = ubxfr_pkg::KIND_START;
          end else begin
            phase_next = ubxfr_pkg::PH_HUNT;
          end
        end
        ubxfr_pkg::PH_HEADER: begin
          push         = 1'b1;
          push_req.pos = {7'd0, count[1:0]};
          case (count[1:0])
            2'd2: begin
              len_next   = {len[15:8], rx_byte};
              count_next = {14'd0, count_inc[1:0]};
            end
            2'd3: begin
              len_next   = {rx_byte, len[7:0]};
              count_next = 16'd0;
              if (full_len > 17'(MAX_PAYLOAD)) begin
                push_req.kind = ubxfr_pkg::KIND_TOOLONG;
                phase_next    = ubxfr_pkg::PH_HUNT;
              end else if (full_len[15:0] == 16'd0) begin
                phase_next = ubxfr_pkg::PH_CHECK_A;
              end else begin
                phase_next = ubxfr_pkg::PH_PAYLOAD;
              end
            end
            default: begin
              count_next = {14'd0, count_inc[1:0]};
            end
          endcase
        end
        ubxfr_pkg::PH_PAYLOAD: begin
          push         = 1'b1;
          push_req.pos = count[8:0] + 9'd4;
          count_next   = count_inc;
          if (count_inc >= len) begin
            phase_next = ubxfr_pkg::PH_CHECK_A;
          end
        end
        ubxfr_pkg::PH_CHECK_A: begin
          push          = 1'b1;
          push_req.kind = ubxfr_pkg::KIND_CHECK_A;
          phase_next    = ubxfr_pkg::PH_CHECK_B;
        end
        ubxfr_pkg::PH_CHECK_B: begin
          push          = 1'b1;
          push_req.kind = ubxfr_pkg::KIND_CHECK_B;
          push_req.pos  = len[8:0] + 9'd5;
          phase_next    = ubxfr_pkg::PH_HUNT;
        end
        default: begin
          // hunting, and any unused phase code
          phase_next = (rx_byte == ubxfr_pkg::SyncFirst) ? ubxfr_pkg::PH_SYNC2
                                                         : ubxfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

endmodule

@@ design/ubxfr_queue.sv @@
// ubxfr_queue: short request FIFO between front and back end.
// Depends on ubxfr_pkg.
`timescale 1ns / 1ps

module ubxfr_queue #(
  parameter int unsigned DEPTH = ubxfr_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ubxfr_pkg::req_t push_req,
  output logic            full,
  output logic            q_valid,
  output ubxfr_pkg::req_t q_req,
  input  logic            pop
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ubxfr_pkg::req_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_req   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("request queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CntW'(DEPTH))
    else $error("request queue count out of range");
`endif

endmodule

@@ design/ubxfr_back.sv @@
// ubxfr_back: checksum unit and output register; executes queued requests.
// Depends on ubxfr_pkg.
`timescale 1ns / 1ps

module ubxfr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ubxfr_pkg::req_t q_req,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      data_byte,
  output logic [8:0]      byte_pos,
  output logic            frame_end,
  output logic [1:0]      frame_status
);

  logic [7:0] sum_a, sum_b, first_check;
  logic [7:0] acc_a;
  logic       emits;
  logic       good;
  ubxfr_pkg::status_t status_next;
  logic       end_next;

  assign pop   = q_valid && (!out_valid || !out_stall);
  assign acc_a = sum_a + q_req.data;
  assign good  = (first_check == sum_a) && (q_req.data == sum_b);

  always_comb begin
    emits       = 1'b0;
    end_next    = 1'b0;
    status_next = ubxfr_pkg::ST_OK;
    case (q_req.kind)
      ubxfr_pkg::KIND_DATA: begin
        emits = 1'b1;
      end
      ubxfr_pkg::KIND_TOOLONG: begin
        emits       = 1'b1;
        end_next    = 1'b1;
        status_next = ubxfr_pkg::ST_TOOLONG;
      end
      ubxfr_pkg::KIND_CHECK_B: begin
        emits       = 1'b1;
        end_next    = 1'b1;
        status_next = good ? ubxfr_pkg::ST_OK : ubxfr_pkg::ST_BADSUM;
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a       <= 8'd0;
      sum_b       <= 8'd0;
      first_check <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        case (q_req.kind)
          ubxfr_pkg::KIND_START: begin
            sum_a <= 8'd0;
            sum_b <= 8'd0;
          end
          ubxfr_pkg::KIND_DATA, ubxfr_pkg::KIND_TOOLONG: begin
            sum_a <= acc_a;
            sum_b <= sum_b + acc_a;
          end
          ubxfr_pkg::KIND_CHECK_A: begin
            first_check <= q_req.data;
          end
          default: begin
            first_check <= first_check;
          end
        endcase
      end
      if (pop && emits) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      data_byte    <= q_req.data;
      byte_pos     <= q_req.pos;
      frame_end    <= end_next;
      frame_status <= status_next;
    end
  end

`ifndef SYNTHESIS
  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (frame_status == ubxfr_pkg::ST_OK))
    else $error("nonzero status without frame end");
  a_toolong_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end && frame_status == ubxfr_pkg::ST_TOOLONG) |-> (byte_pos == 9'd3))
    else $error("too_long status away from length high byte");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("request executed while output is stalled");
`endif

endmodule

@@ tb/sv/ubx_frame_checker.sv @@
// ubx_frame_checker: watches both channels of the frame receiver, predicts each
// result from the accepted bytes and compares. Depends on ubxfr_pkg.
`timescale 1ns / 1ps

module ubx_frame_checker #(
  parameter int unsigned MAX_LEN = ubxfr_pkg::MaxPayload
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] data_byte,
  input  logic [8:0] byte_pos,
  input  logic       frame_end,
  input  logic [1:0] frame_status,
  output int         mismatches,
  output int         pending,
  output int         checked,
  output int         frames_closed
);

  typedef struct packed {
    logic [7:0]         data;
    logic [8:0]         pos;
    logic               last;
    ubxfr_pkg::status_t status;
  } rx_result_t;

  rx_result_t expected_q[$];

  // receiver state as tracked from the accepted bytes
  ubxfr_pkg::phase_t phase;
  logic [7:0] sum_a;
  logic [7:0] sum_b;
  logic [15:0] hdr_len;
  logic [15:0] idx_count;
  logic [7:0] held_check;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic push_result(input logic [7:0] b, input logic [8:0] pos, input logic last,
                             input ubxfr_pkg::status_t st);
    rx_result_t r;
    r.data   = b;
    r.pos    = pos;
    r.last   = last;
    r.status = st;
    expected_q.push_back(r);
  endtask

  task automatic track_byte(input logic [7:0] b);
    logic [1:0]  idx;
    logic [16:0] pos;
    case (phase)
      ubxfr_pkg::PH_SYNC2: begin
        if (b == ubxfr_pkg::SyncSecond) begin
          phase     = ubxfr_pkg::PH_HEADER;
          sum_a     = 8'd0;
          sum_b     = 8'd0;
          idx_count = 16'd0;
          hdr_len   = 16'd0;
        end else begin
          phase = ubxfr_pkg::PH_HUNT;  // this byte is not looked at again as a sync byte
        end
      end
      ubxfr_pkg::PH_HEADER: begin
        idx   = idx_count[1:0];
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
        if (idx == 2'd3) begin
          hdr_len[15:8] = b;
          idx_count     = 16'd0;
          if (hdr_len > MAX_LEN) begin
            phase = ubxfr_pkg::PH_HUNT;
            push_result(b, 9'd3, 1'b1, ubxfr_pkg::ST_TOOLONG);
          end else begin
            if (hdr_len == 16'd0) phase = ubxfr_pkg::PH_CHECK_A;
            else phase = ubxfr_pkg::PH_PAYLOAD;
            push_result(b, 9'd3, 1'b0, ubxfr_pkg::ST_OK);
          end
        end else begin
          if (idx == 2'd2) hdr_len[7:0] = b;
          idx_count = {14'd0, idx} + 16'd1;
          push_result(b, {7'd0, idx}, 1'b0, ubxfr_pkg::ST_OK);
        end
      end
      ubxfr_pkg::PH_PAYLOAD: begin
        pos       = 17'd4 + idx_count;
        sum_a     = sum_a + b;
        sum_b     = sum_b + sum_a;
        idx_count = idx_count + 16'd1;
        if (idx_count >= hdr_len) phase = ubxfr_pkg::PH_CHECK_A;
        push_result(b, pos[8:0], 1'b0, ubxfr_pkg::ST_OK);
      end
      ubxfr_pkg::PH_CHECK_A: begin
        held_check = b;
        phase      = ubxfr_pkg::PH_CHECK_B;
      end
      ubxfr_pkg::PH_CHECK_B: begin
        pos   = 17'd5 + hdr_len;
        phase = ubxfr_pkg::PH_HUNT;
        if (held_check == sum_a && b == sum_b)
          push_result(b, pos[8:0], 1'b1, ubxfr_pkg::ST_OK);
        else push_result(b, pos[8:0], 1'b1, ubxfr_pkg::ST_BADSUM);
      end
      default: begin
        if (b == ubxfr_pkg::SyncFirst) phase = ubxfr_pkg::PH_SYNC2;
        else phase = ubxfr_pkg::PH_HUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin
    rx_result_t want;
    if (rst) begin
      phase         = ubxfr_pkg::PH_HUNT;
      sum_a         = 8'd0;
      sum_b         = 8'd0;
      hdr_len       = 16'd0;
      idx_count     = 16'd0;
      held_check    = 8'd0;
      mismatches    = 0;
      checked       = 0;
      frames_closed = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, byte %0h pos %0d",
                                    data_byte, byte_pos));
        end else begin
          want = expected_q.pop_front();
          if (data_byte !== want.data)
            report_mismatch($sformatf("data_byte got %0h want %0h", data_byte, want.data));
          if (byte_pos !== want.pos)
            report_mismatch($sformatf("byte_pos got %0d want %0d", byte_pos, want.pos));
          if (frame_end !== want.last)
            report_mismatch($sformatf("frame_end got %0b want %0b", frame_end, want.last));
          if (frame_status !== want.status)
            report_mismatch($sformatf("frame_status got %0d want %0d",
                                      frame_status, want.status));
          checked = checked + 1;
          if (want.last) frames_closed = frames_closed + 1;
        end
      end
      if (in_valid && !in_stall) track_byte(rx_byte);
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: stimulus and verdict for ubx_frame_receiver_top. Builds framed byte
// streams plus noise; ubx_frame_checker does the prediction. Depends on ubxfr_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;  // long output hold-off to fill the block
  localparam int unsigned PhaseBytes  = 320;  // bytes per idle mix

  // how the trailing check bytes of a built frame are spoiled, if at all
  typedef enum int {
    CHK_GOOD     = 0,
    CHK_BAD_A    = 1,
    CHK_BAD_B    = 2,
    CHK_BAD_BOTH = 3
  } check_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte;
  logic [8:0] byte_pos;
  logic       frame_end;
  logic [1:0] frame_status;

  int mismatches;
  int pending;
  int checked;
  int frames_closed;

  int bytes_sent    = 0;
  int frames_built  = 0;
  int send_idle_pct = 0;  // chance per request that the sender skips a cycle
  int recv_idle_pct = 0;  // chance per cycle that the sink stalls
  int cycles        = 0;

  event hold_go;
  logic holding = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ubx_frame_receiver_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_pos     (byte_pos),
    .frame_end    (frame_end),
    .frame_status (frame_status)
  );

  ubx_frame_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_byte     (data_byte),
    .byte_pos      (byte_pos),
    .frame_end     (frame_end),
    .frame_status  (frame_status),
    .mismatches    (mismatches),
    .pending       (pending),
    .checked       (checked),
    .frames_closed (frames_closed)
  );

  // Sink side: random stalls, or a solid hold-off while holding is set.
  always @(negedge clk) begin
    out_stall <= holding || ($urandom_range(99) < recv_idle_pct);
  end

  // Hold-off counter runs in its own process; the sender keeps offering bytes,
  // so the two-entry queue fills and in_stall has to come up.
  always begin
    @(hold_go);
    @(posedge clk);
    holding = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // One request on the input channel. Drive at the falling edge, look for the
  // handshake at the rising edge; returns right after the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent = bytes_sent + 1;
  endtask

  // Sync pair, header, payload and check bytes. A length over the limit stops
  // after the header since the block drops back to hunting there.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input check_mode_t mode);
    logic [7:0] hdr [4];
    logic [7:0] fa;
    logic [7:0] fb;
    logic [7:0] pb;
    hdr[0] = cls;
    hdr[1] = id;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    fa = 8'd0;
    fb = 8'd0;
    frames_built = frames_built + 1;
    send_byte(ubxfr_pkg::SyncFirst);
    send_byte(ubxfr_pkg::SyncSecond);
    for (int i = 0; i < 4; i++) begin
      fa = fa + hdr[i];
      fb = fb + fa;
      send_byte(hdr[i]);
    end
    if (len > ubxfr_pkg::MaxPayload) return;
    for (int i = 0; i < int'(len); i++) begin
      pb = 8'($urandom);
      fa = fa + pb;
      fb = fb + fa;
      send_byte(pb);
    end
    if (mode == CHK_BAD_A || mode == CHK_BAD_BOTH) fa = fa ^ 8'($urandom_range(255, 1));
    if (mode == CHK_BAD_B || mode == CHK_BAD_BOTH) fb = fb ^ 8'($urandom_range(255, 1));
    send_byte(fa);
    send_byte(fb);
  endtask

  // One random slice of traffic: mostly well-formed frames with random
  // content, the rest oversized headers, line noise and broken frames.
  task automatic random_chunk();
    int          pick;
    int          n;
    logic [15:0] len;
    logic [7:0]  pb;
    check_mode_t mode;
    pick = $urandom_range(99);
    if (pick < 65) begin
      len  = ($urandom_range(39) == 0) ? 16'(ubxfr_pkg::MaxPayload)
                                       : 16'($urandom_range(12));
      mode = ($urandom_range(9) < 7) ? CHK_GOOD : check_mode_t'($urandom_range(3, 1));
      send_frame(8'($urandom), 8'($urandom), len, mode);
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0:       len = 16'hFFFF;
        1:       len = 16'(ubxfr_pkg::MaxPayload + 1);
        default: len = 16'($urandom_range(65535, ubxfr_pkg::MaxPayload + 1));
      endcase
      send_frame(8'($urandom), 8'($urandom), len, CHK_GOOD);
    end else if (pick < 85) begin
      // noise, heavy on first sync bytes
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(2) == 0) send_byte(ubxfr_pkg::SyncFirst);
        else send_byte(8'($urandom));
      end
    end else if (pick < 93) begin
      // first sync byte followed by anything but the second one
      pb = 8'($urandom);
      if (pb == ubxfr_pkg::SyncSecond) pb = ubxfr_pkg::SyncFirst;
      send_byte(ubxfr_pkg::SyncFirst);
      send_byte(pb);
    end else begin
      // header cut short; whatever follows is taken as the rest of the frame
      send_byte(ubxfr_pkg::SyncFirst);
      send_byte(ubxfr_pkg::SyncSecond);
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle bytes at both extremes, a bad second sync byte that is
    // itself a first sync byte, an empty frame, a one-byte frame with a bad
    // second check byte, and a header one over the length limit.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ubxfr_pkg::SyncFirst);
    send_byte(ubxfr_pkg::SyncFirst);
    send_byte(ubxfr_pkg::SyncSecond);
    send_frame(8'hFF, 8'h00, 16'd0, CHK_GOOD);
    send_frame(8'h00, 8'hFF, 16'd1, CHK_BAD_B);
    send_frame(8'h01, 8'h02, 16'(ubxfr_pkg::MaxPayload + 1), CHK_GOOD);

    // Random part in four idle mixes.
    for (int p = 0; p < 4; p++) begin
      int start_bytes;
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 50;
        end
        default: begin
          send_idle_pct = 15;
          recv_idle_pct = 15;
        end
      endcase
      start_bytes = bytes_sent;
      if (p == 0) begin
        // largest legal payload, then a frame pushed against the hold-off
        send_frame(8'h55, 8'hAA, 16'(ubxfr_pkg::MaxPayload), CHK_GOOD);
        -> hold_go;
        send_frame(8'h0A, 8'h0B, 16'd40, CHK_GOOD);
      end
      while (bytes_sent - start_bytes < PhaseBytes) random_chunk();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then wait for anything stray
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("summary: %0d bytes sent, %0d frames built, idle mixes none/send/sink/both",
             bytes_sent, frames_built);
    $display("summary: %0d results compared, %0d frames closed, one long sink hold-off",
             checked, frames_closed);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ubxfr_pkg.sv
design/ubxfr_front.sv
design/ubxfr_queue.sv
design/ubxfr_back.sv
design/ubx_frame_receiver_top.sv
tb/sv/ubx_frame_checker.sv
tb/sv/tb_top.sv
